[hdl/breath_hold_dive_tracker_defines.svh]
// Assertion macros for the breath-hold dive tracker.
// Taken in by the checker; depends on nothing else.
`ifndef BREATH_HOLD_DIVE_TRACKER_DEFINES_SVH
`define BREATH_HOLD_DIVE_TRACKER_DEFINES_SVH

// same-cycle implication, held off during reset
`define BHDT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bhdt: same-cycle check failed");

// next-cycle implication, held off during reset
`define BHDT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bhdt: next-cycle check failed");

`endif

[hdl/bhdt_pkg.sv]
// Shared constants, types and helpers for the breath-hold dive tracker.
// No dependencies; used by the top level.
`default_nettype none

package bhdt_pkg;

   localparam int DEPTH_BITS = 16;
   localparam int STAMP_BITS = 48;
   localparam int CMP_BITS   = (DEPTH_BITS > 16) ? DEPTH_BITS : 16;

   localparam int            CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_THR = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_END_THR   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REC_LIMIT = 2'd2;

   localparam logic [15:0] START_THR_RESET = 16'd50;
   localparam logic [15:0] END_THR_RESET   = 16'd30;
   localparam logic [15:0] REC_LIMIT_RESET = 16'd600;
   localparam logic [15:0] SAT16           = 16'hFFFF;

   // seconds = floor((diff >> 6) / 15625), exact by reciprocal for 30-bit operands
   localparam int PRE_SHIFT   = 6;
   localparam int SAT_SHIFT   = 36;
   localparam int X_BITS      = (STAMP_BITS > SAT_SHIFT) ? (SAT_SHIFT - PRE_SHIFT)
                                                         : (STAMP_BITS - PRE_SHIFT);
   localparam int RECIP_BITS  = 31;
   localparam logic [RECIP_BITS-1:0] RECIP = 31'd1125899907;
   localparam int RECIP_SHIFT = 44;
   localparam int PROD_BITS   = X_BITS + RECIP_BITS;
   localparam int QUO_BITS    = PROD_BITS - RECIP_SHIFT;

   typedef struct packed {
      logic        diving;
      logic        in_dive;
      logic        ended;
      logic        report;
      logic [15:0] dive_max;
      logic [15:0] session_max;
      logic [15:0] count;
   } stage_info_type;

   function automatic logic [15:0] cm16(input logic [DEPTH_BITS-1:0] v);
      logic [CMP_BITS-1:0] w;
      w = CMP_BITS'(v);
      return w[15:0];
   endfunction

endpackage

`default_nettype wire

[hdl/breath_hold_dive_tracker.sv]
// rsp_valid rises once an accepted req word has passed three register stages (s1, s2, result).
// Throughput: one word per cycle while rsp_stall is low; the reciprocal multiplier has its own stage.
// Dive state updates at accept; elapsed-seconds state updates at the result register.
// Reset (synchronous, active high): dive state and dive-time registers cleared, thresholds to
// 50 cm / 30 cm, recovery limit to 600 s, pipeline emptied; other result data registers not reset.
`default_nettype none

module breath_hold_dive_tracker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_en,
   input  logic [bhdt_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [15:0]                            csr_write_data,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [bhdt_pkg::DEPTH_BITS-1:0]        req_depth_cm,
   input  logic [bhdt_pkg::STAMP_BITS-1:0]        req_time_us,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_diving,
   output logic [15:0]                            rsp_dive_time_s,
   output logic [15:0]                            rsp_dive_max_cm,
   output logic [15:0]                            rsp_session_max_cm,
   output logic [15:0]                            rsp_dive_count,
   output logic [15:0]                            rsp_longest_dive_s,
   output logic [15:0]                            rsp_last_dive_s,
   output logic                                   rsp_dive_ended,
   output logic [15:0]                            rsp_rest_time_s,
   output logic                                   rsp_recovery_visible,
   output logic                                   rsp_recovery_red
);
   import bhdt_pkg::*;

   logic [15:0] start_thr_ff, start_thr_in;
   logic [15:0] end_thr_ff, end_thr_in;
   logic [15:0] rec_limit_ff, rec_limit_in;

   logic                  in_dive_ff, in_dive_in;
   logic                  has_dived_ff, has_dived_in;
   logic [STAMP_BITS-1:0] dive_start_ff, dive_start_in;
   logic [STAMP_BITS-1:0] surface_start_ff, surface_start_in;
   logic [DEPTH_BITS-1:0] dive_peak_ff, dive_peak_in;
   logic [DEPTH_BITS-1:0] session_peak_ff, session_peak_in;
   logic [15:0]           dives_ff, dives_in;

   logic                  s1_valid_ff, s1_valid_in;
   stage_info_type        s1_info_ff, s1_info_in;
   logic [STAMP_BITS-1:0] s1_diff_ff, s1_diff_in;

   logic                  s2_valid_ff, s2_valid_in;
   stage_info_type        s2_info_ff, s2_info_in;
   logic [PROD_BITS-1:0]  s2_prod_ff, s2_prod_in;
   logic                  s2_over_ff, s2_over_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        diving_ff, diving_in;
   logic [15:0] cur_secs_ff, cur_secs_in;
   logic [15:0] dive_max_ff, dive_max_in;
   logic [15:0] session_max_ff, session_max_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] longest_ff, longest_in;
   logic [15:0] prev_secs_ff, prev_secs_in;
   logic        ended_ff, ended_in;
   logic [15:0] rec_ff, rec_in;
   logic        vis_ff, vis_in;
   logic        red_ff, red_in;

   logic adv_out, adv2, adv1, accept;

   logic [CMP_BITS-1:0]   depth_w;
   logic                  start_hit, mid_dive, end_hit;
   logic [DEPTH_BITS-1:0] peak_base;
   logic [STAMP_BITS-1:0] base_time;

   logic [X_BITS-1:0]   x_val;
   logic [QUO_BITS-1:0] quo;
   logic                quo_big;
   logic [15:0]         secs;

   always_comb begin
      adv_out   = !rsp_valid_ff || !rsp_stall;
      adv2      = !s2_valid_ff || adv_out;
      adv1      = !s1_valid_ff || adv2;
      req_stall = !adv1;
      accept    = req_valid && adv1;
   end

   always_comb begin
      start_thr_in = start_thr_ff;
      end_thr_in   = end_thr_ff;
      rec_limit_in = rec_limit_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_START_THR: start_thr_in = csr_write_data;
            CSR_END_THR:   end_thr_in   = csr_write_data;
            CSR_REC_LIMIT: rec_limit_in = csr_write_data;
            default:       ;
         endcase
      end
   end

   always_comb begin
      depth_w   = CMP_BITS'(req_depth_cm);
      start_hit = !in_dive_ff && (depth_w > CMP_BITS'(start_thr_ff));
      mid_dive  = in_dive_ff || start_hit;
      end_hit   = mid_dive && (depth_w < CMP_BITS'(end_thr_ff));
      peak_base = start_hit ? '0 : dive_peak_ff;

      in_dive_in       = in_dive_ff;
      has_dived_in     = has_dived_ff;
      dive_start_in    = dive_start_ff;
      surface_start_in = surface_start_ff;
      dive_peak_in     = dive_peak_ff;
      session_peak_in  = session_peak_ff;
      dives_in         = dives_ff;

      if (accept) begin
         in_dive_in = mid_dive && !end_hit;
         if (start_hit) begin
            dive_start_in = req_time_us;
            if (dives_ff != SAT16) begin
               dives_in = dives_ff + 16'd1;
            end
         end
         if (mid_dive) begin
            dive_peak_in    = (req_depth_cm > peak_base) ? req_depth_cm : peak_base;
            session_peak_in = (req_depth_cm > session_peak_ff) ? req_depth_cm
                                                                 : session_peak_ff;
         end
         if (end_hit) begin
            has_dived_in     = 1'b1;
            surface_start_in = req_time_us;
         end
      end

      if (mid_dive) begin
         base_time = start_hit ? req_time_us : dive_start_ff;
      end else begin
         base_time = surface_start_ff;
      end

      s1_valid_in = adv1 ? req_valid : s1_valid_ff;
      s1_info_in  = s1_info_ff;
      s1_diff_in  = s1_diff_ff;
      if (accept) begin
         s1_diff_in             = req_time_us - base_time;
         s1_info_in.diving      = in_dive_in;
         s1_info_in.in_dive     = mid_dive;
         s1_info_in.ended       = end_hit;
         s1_info_in.report      = !mid_dive && has_dived_ff;
         s1_info_in.dive_max    = cm16(dive_peak_in);
         s1_info_in.session_max = cm16(session_peak_in);
         s1_info_in.count       = dives_in;
      end
   end

   always_comb begin
      x_val       = s1_diff_ff[PRE_SHIFT +: X_BITS];
      s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;
      s2_info_in  = s2_info_ff;
      s2_prod_in  = s2_prod_ff;
      s2_over_in  = s2_over_ff;
      if (adv2 && s1_valid_ff) begin
         s2_info_in = s1_info_ff;
         s2_prod_in = PROD_BITS'(x_val) * PROD_BITS'(RECIP);
         s2_over_in = (s1_diff_ff >> SAT_SHIFT) != '0;
      end
   end

   always_comb begin
      quo     = s2_prod_ff[RECIP_SHIFT +: QUO_BITS];
      quo_big = (quo >> 16) != '0;
      secs    = (s2_over_ff || quo_big) ? SAT16 : 16'(quo);

      rsp_valid_in   = adv_out ? s2_valid_ff : rsp_valid_ff;
      diving_in      = diving_ff;
      cur_secs_in    = cur_secs_ff;
      dive_max_in    = dive_max_ff;
      session_max_in = session_max_ff;
      count_in       = count_ff;
      longest_in     = longest_ff;
      prev_secs_in   = prev_secs_ff;
      ended_in       = ended_ff;
      rec_in         = rec_ff;
      vis_in         = vis_ff;
      red_in         = red_ff;
      if (adv_out && s2_valid_ff) begin
         diving_in      = s2_info_ff.diving;
         dive_max_in    = s2_info_ff.dive_max;
         session_max_in = s2_info_ff.session_max;
         count_in       = s2_info_ff.count;
         ended_in       = s2_info_ff.ended;
         if (s2_info_ff.in_dive) begin
            cur_secs_in = secs;
         end
         if (s2_info_ff.ended) begin
            prev_secs_in = secs;
            if (secs > longest_ff) begin
               longest_in = secs;
            end
         end
         rec_in = s2_info_ff.report ? secs : 16'd0;
         vis_in = s2_info_ff.report && (secs < rec_limit_ff);
         red_in = s2_info_ff.report && (secs < rec_limit_ff)
                  && ({1'b0, secs} < {prev_secs_ff, 1'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_thr_ff     <= START_THR_RESET;
         end_thr_ff       <= END_THR_RESET;
         rec_limit_ff     <= REC_LIMIT_RESET;
         in_dive_ff       <= 1'b0;
         has_dived_ff     <= 1'b0;
         dive_start_ff    <= '0;
         surface_start_ff <= '0;
         dive_peak_ff     <= '0;
         session_peak_ff  <= '0;
         dives_ff         <= '0;
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         cur_secs_ff      <= '0;
         longest_ff       <= '0;
         prev_secs_ff     <= '0;
      end else begin
         start_thr_ff     <= start_thr_in;
         end_thr_ff       <= end_thr_in;
         rec_limit_ff     <= rec_limit_in;
         in_dive_ff       <= in_dive_in;
         has_dived_ff     <= has_dived_in;
         dive_start_ff    <= dive_start_in;
         surface_start_ff <= surface_start_in;
         dive_peak_ff     <= dive_peak_in;
         session_peak_ff  <= session_peak_in;
         dives_ff         <= dives_in;
         s1_valid_ff      <= s1_valid_in;
         s2_valid_ff      <= s2_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         cur_secs_ff      <= cur_secs_in;
         longest_ff       <= longest_in;
         prev_secs_ff     <= prev_secs_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_info_ff     <= s1_info_in;
      s1_diff_ff     <= s1_diff_in;
      s2_info_ff     <= s2_info_in;
      s2_prod_ff     <= s2_prod_in;
      s2_over_ff     <= s2_over_in;
      diving_ff      <= diving_in;
      dive_max_ff    <= dive_max_in;
      session_max_ff <= session_max_in;
      count_ff       <= count_in;
      ended_ff       <= ended_in;
      rec_ff         <= rec_in;
      vis_ff         <= vis_in;
      red_ff         <= red_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_diving           = diving_ff;
   assign rsp_dive_time_s      = cur_secs_ff;
   assign rsp_dive_max_cm      = dive_max_ff;
   assign rsp_session_max_cm   = session_max_ff;
   assign rsp_dive_count       = count_ff;
   assign rsp_longest_dive_s   = longest_ff;
   assign rsp_last_dive_s      = prev_secs_ff;
   assign rsp_dive_ended       = ended_ff;
   assign rsp_rest_time_s      = rec_ff;
   assign rsp_recovery_visible = vis_ff;
   assign rsp_recovery_red     = red_ff;

endmodule

`default_nettype wire

[hdl/bhdt_checker.sv]
// Port-level checks on the breath-hold dive tracker result channel.
// Depends on breath_hold_dive_tracker_defines.svh; bound to the top level below.
`default_nettype none
`include "breath_hold_dive_tracker_defines.svh"

module bhdt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_diving,
   input logic        rsp_dive_ended,
   input logic        rsp_recovery_visible,
   input logic        rsp_recovery_red,
   input logic [15:0] rsp_dive_count
);

   `BHDT_ASSERT_IMP(a_end_surfaced, clock, reset, rsp_valid && rsp_dive_ended, !rsp_diving)
   `BHDT_ASSERT_IMP(a_red_visible, clock, reset, rsp_valid && rsp_recovery_red, rsp_recovery_visible)
   `BHDT_ASSERT_IMP(a_vis_surface, clock, reset, rsp_valid && rsp_recovery_visible, !rsp_diving && !rsp_dive_ended)
   `BHDT_ASSERT_NXT(a_hold_word, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_dive_count))

endmodule

bind breath_hold_dive_tracker bhdt_checker u_bhdt_checker (.*);

`default_nettype wire
